>>> rtl/core/lsd_pkg.sv
// Shared types and constants for the local signed distance block.
`default_nettype none

package lsd_pkg;

  // Request codes carried in the action field.
  localparam logic [2:0] ACT_WR_FRAC = 3'd0;
  localparam logic [2:0] ACT_WR_X    = 3'd1;
  localparam logic [2:0] ACT_WR_Y    = 3'd2;
  localparam logic [2:0] ACT_WR_Z    = 3'd3;
  localparam logic [2:0] ACT_QUERY   = 3'd4;

  // Fraction scale: Q1.16 with one full cell at 65536.
  localparam logic [16:0] FRAC_ONE  = 17'd65536;
  localparam logic [16:0] FRAC_HALF = 17'd32768;

  // Search limit after reset, 10.0 in Q16.16.
  localparam logic [30:0] LIMIT_RESET = 31'd655360;

  // Status codes of a result.
  localparam logic STAT_OK       = 1'b0;
  localparam logic STAT_INTERIOR = 1'b1;

  typedef struct packed {
    logic [2:0]         action;
    logic [4:0]         cell_x;
    logic [4:0]         cell_y;
    logic [4:0]         cell_z;
    logic signed [31:0] value;
  } lsd_req_t;

  typedef struct packed {
    logic signed [31:0] distance;
    logic               status;
  } lsd_res_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;
    logic init;
    logic cap_centre;
    logic scan_en;
    logic sqrt_init;
    logic sqrt_en;
    logic emit;
    logic emit_err;
  } lsd_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic query;
    logic interior;
    logic scan_last;
    logic sqrt_last;
  } lsd_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/lsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/lsd_ctrl.sv
// Controller state machine that sequences a query through the datapath.
`default_nettype none

module lsd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output logic                   out_valid,
  input  wire lsd_pkg::lsd_stat_t stat,
  output lsd_pkg::lsd_cmd_t      cmd
);
  import lsd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_CENTRE, ST_CAPTURE, ST_SCAN,
    ST_DRAIN, ST_SQ_INIT, ST_SQRT, ST_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic       err_r, err_nxt;
  logic [1:0] drain_r, drain_nxt;
  logic       out_valid_r;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    drain_nxt = drain_r;
    cmd       = '0;
    cmd.accept = start && (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept && stat.query) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        err_nxt   = !stat.interior;
        state_nxt = stat.interior ? ST_CENTRE : ST_EMIT;
      end
      ST_CENTRE: begin
        cmd.init  = 1'b1;
        state_nxt = ST_CAPTURE;
      end
      ST_CAPTURE: begin
        cmd.cap_centre = 1'b1;
        state_nxt      = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        drain_nxt   = '0;
        if (stat.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r + 2'd1;
        if (drain_r == 2'd3) begin
          state_nxt = ST_SQ_INIT;
        end
      end
      ST_SQ_INIT: begin
        cmd.sqrt_init = 1'b1;
        state_nxt     = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_en = 1'b1;
        if (stat.sqrt_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit     = 1'b1;
        cmd.emit_err = err_r;
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      err_r       <= 1'b0;
      drain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      err_r       <= err_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= (state_r == ST_EMIT);
    end
  end

  // An accepted query makes the block busy in the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && stat.query) |=> busy)
    else $error("query accepted but block not busy");

  // A result only follows a cycle of work.
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a query in progress");

  // One strobe per query.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held two cycles");

endmodule

`default_nettype wire

>>> rtl/core/lsd_dp.sv
// Datapath: grid and coordinate stores, neighbour scan pipeline, square root.
`default_nettype none

module lsd_dp #(
  parameter int GRID_X        = 16,
  parameter int GRID_Y        = 16,
  parameter int GRID_Z        = 16,
  parameter int KERNEL_RADIUS = 3
) (
  input  wire logic              clk,
  input  wire lsd_pkg::lsd_req_t in_req,
  input  wire logic [30:0]       limit,
  input  wire lsd_pkg::lsd_cmd_t cmd,
  output lsd_pkg::lsd_stat_t     stat,
  output lsd_pkg::lsd_res_t      out_res
);
  import lsd_pkg::*;

  localparam int XW    = $clog2(GRID_X);
  localparam int YW    = $clog2(GRID_Y);
  localparam int ZW    = $clog2(GRID_Z);
  localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
  localparam int GW    = $clog2(CELLS);
  localparam int KMAX  = 2 * KERNEL_RADIUS;
  localparam int OW    = $clog2(KMAX + 1);
  // Offset sum holds a 5-bit index plus the kernel span.
  localparam int SW    = 6 + OW;

  // Grid address of a zero-based cell.
  function automatic logic [GW-1:0] cell_addr(input logic [XW-1:0] x,
                                              input logic [YW-1:0] y,
                                              input logic [ZW-1:0] z);
    int a;
    a = (int'(x) * GRID_Y + int'(y)) * GRID_Z + int'(z);
    return a[GW-1:0];
  endfunction

  // Absolute difference of two signed coordinates, fits 32 bits.
  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    return d[32] ? 32'(-d) : d[31:0];
  endfunction

  // Saturating 64-bit add.
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // Input write decode.
  logic        okx, oky, okz;
  logic [16:0] frac_sat;
  assign okx = (in_req.cell_x >= 5'd1) && (int'(in_req.cell_x) <= GRID_X);
  assign oky = (in_req.cell_y >= 5'd1) && (int'(in_req.cell_y) <= GRID_Y);
  assign okz = (in_req.cell_z >= 5'd1) && (int'(in_req.cell_z) <= GRID_Z);
  always_comb begin
    if (in_req.value < 0) begin
      frac_sat = '0;
    end else if (in_req.value > 32'sd65536) begin
      frac_sat = FRAC_ONE;
    end else begin
      frac_sat = in_req.value[16:0];
    end
  end

  logic [XW-1:0] wx;
  logic [YW-1:0] wy;
  logic [ZW-1:0] wz;
  assign wx = XW'(in_req.cell_x - 5'd1);
  assign wy = YW'(in_req.cell_y - 5'd1);
  assign wz = ZW'(in_req.cell_z - 5'd1);

  logic we_frac, we_x, we_y, we_z;
  assign we_frac = cmd.accept && (in_req.action == ACT_WR_FRAC) && okx && oky && okz;
  assign we_x    = cmd.accept && (in_req.action == ACT_WR_X) && okx;
  assign we_y    = cmd.accept && (in_req.action == ACT_WR_Y) && oky;
  assign we_z    = cmd.accept && (in_req.action == ACT_WR_Z) && okz;

  // Query request held for the whole query.
  lsd_req_t req_r;
  always_ff @(posedge clk) begin
    if (cmd.accept && (in_req.action == ACT_QUERY)) begin
      req_r <= in_req;
    end
  end

  assign stat.query    = (in_req.action == ACT_QUERY);
  assign stat.interior = (req_r.cell_x >= 5'd2) && (int'(req_r.cell_x) <= GRID_X - 1) &&
                         (req_r.cell_y >= 5'd2) && (int'(req_r.cell_y) <= GRID_Y - 1) &&
                         (req_r.cell_z >= 5'd2) && (int'(req_r.cell_z) <= GRID_Z - 1);

  // Neighbour scan counters, z fastest.
  logic [OW-1:0] ox_r, oy_r, oz_r;
  assign stat.scan_last = (int'(ox_r) == KMAX) && (int'(oy_r) == KMAX) &&
                          (int'(oz_r) == KMAX);
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      ox_r <= '0;
      oy_r <= '0;
      oz_r <= '0;
    end else if (cmd.scan_en) begin
      if (int'(oz_r) == KMAX) begin
        oz_r <= '0;
        if (int'(oy_r) == KMAX) begin
          oy_r <= '0;
          ox_r <= ox_r + OW'(1);
        end else begin
          oy_r <= oy_r + OW'(1);
        end
      end else begin
        oz_r <= oz_r + OW'(1);
      end
    end
  end

  // Neighbour index = centre + offset - radius, one based; range checked here.
  logic [SW-1:0] sx, sy, sz;
  logic          inr;
  assign sx  = SW'(req_r.cell_x) + SW'(ox_r);
  assign sy  = SW'(req_r.cell_y) + SW'(oy_r);
  assign sz  = SW'(req_r.cell_z) + SW'(oz_r);
  assign inr = (int'(sx) >= KERNEL_RADIUS + 1) && (int'(sx) <= KERNEL_RADIUS + GRID_X) &&
               (int'(sy) >= KERNEL_RADIUS + 1) && (int'(sy) <= KERNEL_RADIUS + GRID_Y) &&
               (int'(sz) >= KERNEL_RADIUS + 1) && (int'(sz) <= KERNEL_RADIUS + GRID_Z);

  logic [SW-1:0] nx, ny, nz;
  assign nx = sx - SW'(KERNEL_RADIUS + 1);
  assign ny = sy - SW'(KERNEL_RADIUS + 1);
  assign nz = sz - SW'(KERNEL_RADIUS + 1);

  // Read address: neighbour while scanning, otherwise the centre cell.
  logic [XW-1:0] rx;
  logic [YW-1:0] ry;
  logic [ZW-1:0] rz;
  assign rx = cmd.scan_en ? nx[XW-1:0] : XW'(req_r.cell_x - 5'd1);
  assign ry = cmd.scan_en ? ny[YW-1:0] : YW'(req_r.cell_y - 5'd1);
  assign rz = cmd.scan_en ? nz[ZW-1:0] : ZW'(req_r.cell_z - 5'd1);

  logic [16:0] frac_q;
  logic [31:0] x_q, y_q, z_q;

  lsd_ram #(.WIDTH(17), .DEPTH(CELLS)) u_frac (
    .clk(clk), .we(we_frac), .waddr(cell_addr(wx, wy, wz)), .wdata(frac_sat),
    .raddr(cell_addr(rx, ry, rz)), .rdata(frac_q));
  lsd_ram #(.WIDTH(32), .DEPTH(GRID_X)) u_xc (
    .clk(clk), .we(we_x), .waddr(wx), .wdata(in_req.value), .raddr(rx), .rdata(x_q));
  lsd_ram #(.WIDTH(32), .DEPTH(GRID_Y)) u_yc (
    .clk(clk), .we(we_y), .waddr(wy), .wdata(in_req.value), .raddr(ry), .rdata(y_q));
  lsd_ram #(.WIDTH(32), .DEPTH(GRID_Z)) u_zc (
    .clk(clk), .we(we_z), .waddr(wz), .wdata(in_req.value), .raddr(rz), .rdata(z_q));

  // Centre coordinates and sign, captured after the centre read.
  logic [31:0] cen_x_r, cen_y_r, cen_z_r;
  logic        pos_r;
  always_ff @(posedge clk) begin
    if (cmd.cap_centre) begin
      cen_x_r <= x_q;
      cen_y_r <= y_q;
      cen_z_r <= z_q;
      pos_r   <= (frac_q >= FRAC_HALF);
    end
  end

  // Pipeline: read, absolute differences, squares, partial sum, compare.
  logic        v1_r, v2_r, v3_r, v4_r;
  logic [31:0] adx_r, ady_r, adz_r;
  logic [63:0] sqx_r, sqy_r, sqz_r, sxy_r, sqz_d_r;
  logic        iface;
  assign iface = (frac_q != 17'd0) && (frac_q < FRAC_ONE);

  always_ff @(posedge clk) begin
    v1_r    <= cmd.scan_en && inr;
    v2_r    <= v1_r && iface;
    adx_r   <= abs_diff(cen_x_r, x_q);
    ady_r   <= abs_diff(cen_y_r, y_q);
    adz_r   <= abs_diff(cen_z_r, z_q);
    v3_r    <= v2_r;
    sqx_r   <= adx_r * adx_r;
    sqy_r   <= ady_r * ady_r;
    sqz_r   <= adz_r * adz_r;
    v4_r    <= v3_r;
    sxy_r   <= sat_add(sqx_r, sqy_r);
    sqz_d_r <= sqz_r;
  end

  // Running minimum of the squared distance.
  logic [63:0] best_r;
  logic        found_r;
  logic [63:0] d2;
  assign d2 = sat_add(sxy_r, sqz_d_r);
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      best_r  <= 64'(limit) * 64'(limit);
      found_r <= 1'b0;
    end else if (v4_r && (d2 < best_r)) begin
      best_r  <= d2;
      found_r <= 1'b1;
    end
  end

  // Bitwise square root, one result bit per cycle.
  logic [63:0] rem_r;
  logic [62:0] root_r, bit_r, trial;
  assign trial          = root_r + bit_r;
  assign stat.sqrt_last = bit_r[0];
  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      rem_r  <= best_r;
      root_r <= '0;
      bit_r  <= 63'(1) << 62;
    end else if (cmd.sqrt_en) begin
      if (rem_r >= {1'b0, trial}) begin
        rem_r  <= rem_r - {1'b0, trial};
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // Result register.
  logic [31:0] mag;
  lsd_res_t    res_r;
  assign mag     = found_r ? root_r[31:0] : 32'd0;
  assign out_res = res_r;
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.emit_err) begin
        res_r.distance <= '0;
        res_r.status   <= STAT_INTERIOR;
      end else begin
        res_r.distance <= pos_r ? mag : 32'(-mag);
        res_r.status   <= STAT_OK;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/local_signed_distance_3d.sv
// Top level of the local signed distance block.
//
// Requests arrive on in_req and are taken at a clock edge where start is high
// and busy is low. Actions 0 to 3 write a grid fraction or a centre coordinate
// and finish in that cycle; busy stays low and no result follows. Action 4 is
// a query: busy rises and one result appears on out_res, marked by out_valid
// for one cycle. The receiver cannot stall; results must be taken when shown.
// A query of a non-interior cell goes from the interior check straight to the
// result register and returns a status 1 result. An interior query passes
// through the interior check, the centre read, a scan of (2*KERNEL_RADIUS+1)^3
// grid cells through the single grid memory read port (343 by default), the
// pipeline drain, the square root (a setup step, then one result bit per
// cycle) and the result register; the next request can be taken at the end
// of the strobe cycle. cfg_we and cfg_wdata write the limit register; the user
// must write it only while the block is idle; the block does not enforce it.
// Reset sets the limit to 10.0 and returns the controller to idle; the grid
// and coordinate memories are not cleared and must be written first.
`default_nettype none

module local_signed_distance_3d #(
  parameter int GRID_X        = 16,
  parameter int GRID_Y        = 16,
  parameter int GRID_Z        = 16,
  parameter int KERNEL_RADIUS = 3
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire lsd_pkg::lsd_req_t in_req,
  output logic                   busy,
  output logic                   out_valid,
  output lsd_pkg::lsd_res_t      out_res,
  input  wire logic              cfg_we,
  input  wire logic [30:0]       cfg_wdata
);
  import lsd_pkg::*;

  logic [30:0] limit_r;
  lsd_cmd_t    cmd;
  lsd_stat_t   stat;

  // Search limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  lsd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .stat(stat), .cmd(cmd));

  lsd_dp #(
    .GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z),
    .KERNEL_RADIUS(KERNEL_RADIUS)
  ) u_dp (
    .clk(clk), .in_req(in_req), .limit(limit_r), .cmd(cmd),
    .stat(stat), .out_res(out_res));

endmodule

`default_nettype wire

>>> tb/sv/lsd_checker.sv
// Request monitor, distance predictor and result comparison for the distance block.
`timescale 1ns / 100ps

module lsd_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  lsd_pkg::lsd_req_t in_req,
  input  logic              out_valid,
  input  lsd_pkg::lsd_res_t out_res,
  input  logic              cfg_we,
  input  logic [30:0]       cfg_wdata,
  output int                mismatches,
  output int                pending
);
  import lsd_pkg::*;

  localparam int N   = 16;
  localparam int RAD = 3;

  // Shadow copies of the grid, the cell centres and the search limit.
  logic [16:0] frac_mem [1:N][1:N][1:N];
  logic [31:0] x_mem [1:N];
  logic [31:0] y_mem [1:N];
  logic [31:0] z_mem [1:N];
  logic [30:0] limit_q;

  lsd_res_t distance_q [$];

  // Square of the difference of two signed Q16.16 coordinates.
  function automatic logic [63:0] diff_sq(logic [31:0] a, logic [31:0] b);
    longint d;
    logic [63:0] m;
    d = longint'($signed(a)) - longint'($signed(b));
    m = (d < 0) ? 64'(-d) : 64'(d);
    return m * m;
  endfunction

  function automatic logic [63:0] add_clip(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // Floor square root, one result bit per pass.
  function automatic logic [31:0] floor_root(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[31:0];
  endfunction

  // Result that a query returns: the signed distance of an interior cell, else status 1.
  function automatic lsd_res_t query_distance(int cx, int cy, int cz);
    lsd_res_t r;
    logic [63:0] best;
    logic [63:0] d2;
    logic [16:0] f;
    logic [31:0] mag;
    bit found;
    r.status = STAT_OK;
    if (cx < 2 || cx > N - 1 || cy < 2 || cy > N - 1 || cz < 2 || cz > N - 1) begin
      r.distance = '0;
      r.status   = STAT_INTERIOR;
      return r;
    end
    best  = 64'(limit_q) * 64'(limit_q);
    found = 0;
    for (int nx = cx - RAD; nx <= cx + RAD; nx++) begin
      for (int ny = cy - RAD; ny <= cy + RAD; ny++) begin
        for (int nz = cz - RAD; nz <= cz + RAD; nz++) begin
          if (nx < 1 || nx > N || ny < 1 || ny > N || nz < 1 || nz > N) continue;
          f = frac_mem[nx][ny][nz];
          if (f == 0 || f >= FRAC_ONE) continue;
          d2 = diff_sq(x_mem[cx], x_mem[nx]);
          d2 = add_clip(d2, diff_sq(y_mem[cy], y_mem[ny]));
          d2 = add_clip(d2, diff_sq(z_mem[cz], z_mem[nz]));
          if (d2 < best) begin
            best  = d2;
            found = 1;
          end
        end
      end
    end
    mag = found ? floor_root(best) : '0;
    r.distance = (frac_mem[cx][cy][cz] >= FRAC_HALF) ? mag : -mag;
    return r;
  endfunction

  // Track accepted requests and limit writes.
  always @(posedge clk) begin
    int cx, cy, cz;
    cx = in_req.cell_x;
    cy = in_req.cell_y;
    cz = in_req.cell_z;
    if (!rst_n) begin
      limit_q <= LIMIT_RESET;
    end else begin
      if (cfg_we) limit_q <= cfg_wdata;
      if (start && !busy) begin
        case (in_req.action)
          ACT_WR_FRAC: begin
            if (cx >= 1 && cx <= N && cy >= 1 && cy <= N && cz >= 1 && cz <= N)
              frac_mem[cx][cy][cz] <= (in_req.value < 0) ? 17'd0 :
                  (in_req.value > 32'sd65536) ? FRAC_ONE : in_req.value[16:0];
          end
          ACT_WR_X: if (cx >= 1 && cx <= N) x_mem[cx] <= in_req.value;
          ACT_WR_Y: if (cy >= 1 && cy <= N) y_mem[cy] <= in_req.value;
          ACT_WR_Z: if (cz >= 1 && cz <= N) z_mem[cz] <= in_req.value;
          ACT_QUERY: distance_q.push_back(query_distance(cx, cy, cz));
          default: ;
        endcase
      end
    end
  end

  // Compare each strobed result with the oldest prediction.
  always @(posedge clk) begin
    lsd_res_t want;
    if (rst_n && out_valid) begin
      if (distance_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected result distance=%0d status=%0d",
                   out_res.distance, out_res.status);
      end else begin
        want = distance_q.pop_front();
        if (want.distance !== out_res.distance || want.status !== out_res.status) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected distance=%0d status=%0d, got distance=%0d status=%0d",
                     want.distance, want.status, out_res.distance, out_res.status);
        end
      end
    end
  end

  initial mismatches = 0;
  assign pending = distance_q.size();

endmodule

>>> tb/sv/tb.sv
// Stimulus and verdict for the local signed distance block.
`timescale 1ns / 100ps

module tb;
  import lsd_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  lsd_req_t    in_req = '0;
  logic        busy;
  logic        out_valid;
  lsd_res_t    out_res;
  logic        cfg_we = 0;
  logic [30:0] cfg_wdata = '0;
  int          mismatches;
  int          pending;
  int          cycles = 0;
  int          burst_left = 0;

  always #2 clk = ~clk;

  local_signed_distance_3d i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_req(in_req), .busy(busy),
    .out_valid(out_valid), .out_res(out_res), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  lsd_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending(pending)
  );

  // Give up on a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it.
  task automatic issue(logic [2:0] act, int x, int y, int z, logic [31:0] val);
    start  <= 1'b1;
    in_req <= '{action: act, cell_x: 5'(x), cell_y: 5'(y), cell_z: 5'(z), value: val};
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Requests come in bursts with random gaps between them.
  task automatic paced(logic [2:0] act, int x, int y, int z, logic [31:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) pause(gap);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    issue(act, x, y, z, val);
  endtask

  // Wait until all queries are answered, then set the limit.
  task automatic set_limit(logic [30:0] lim);
    pause(1);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] any_frac();
    case ($urandom_range(0, 9))
      0, 1, 2: return 32'd0;
      3, 4:    return 32'd65536;
      5:       return $urandom;
      6:       return 32'd65536 + $urandom_range(1, 100000);
      default: return $urandom_range(1, 65535);
    endcase
  endfunction

  function automatic logic [31:0] any_coord(int i);
    if ($urandom_range(0, 19) == 0) return $urandom;
    return 32'(i * 65536 + $urandom_range(0, 40000) - 20000);
  endfunction

  function automatic int bad_index();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 1;
      2: return 16;
      default: return $urandom_range(17, 31);
    endcase
  endfunction

  initial begin
    int a, x, y, z;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Coordinates and the low 8x8x8 corner of the grid get values first;
    // interior queries stay at 2..5 so their neighbourhoods lie inside it.
    for (int i = 1; i <= 16; i++) begin
      issue(ACT_WR_X, i, 0, 0, 32'(i * 65536));
      issue(ACT_WR_Y, 0, i, 0, 32'(i * 65536 + 3000));
      issue(ACT_WR_Z, 0, 0, i, 32'(i * 65536 - 7000));
    end
    for (int i = 1; i <= 8; i++)
      for (int j = 1; j <= 8; j++)
        for (int k = 1; k <= 8; k++)
          issue(ACT_WR_FRAC, i, j, k, any_frac());

    // Directed cases: saturation, ignored writes, sign threshold, edges.
    issue(ACT_WR_FRAC, 5, 5, 5, 32'd32768);
    issue(ACT_QUERY, 5, 5, 5, '0);
    issue(ACT_WR_FRAC, 5, 5, 5, 32'd32767);
    issue(ACT_QUERY, 5, 5, 5, 32'hFFFFFFFF);
    issue(ACT_WR_FRAC, 5, 5, 5, 32'h80000000);
    issue(ACT_QUERY, 5, 5, 5, '0);
    issue(ACT_WR_FRAC, 5, 5, 5, 32'h7FFFFFFF);
    issue(ACT_QUERY, 5, 5, 5, '0);
    issue(ACT_WR_FRAC, 0, 8, 8, 32'd100);
    issue(ACT_WR_FRAC, 8, 17, 8, 32'd100);
    issue(ACT_WR_X, 31, 0, 0, 32'h12345678);
    issue(ACT_WR_Z, 0, 0, 0, 32'h12345678);
    issue(3'd5, 8, 8, 8, '1);
    issue(3'd6, 8, 8, 8, '1);
    issue(3'd7, 31, 31, 31, '1);
    issue(ACT_QUERY, 2, 2, 2, '0);
    issue(ACT_QUERY, 2, 5, 2, '0);
    issue(ACT_QUERY, 1, 8, 8, '0);
    issue(ACT_QUERY, 8, 16, 8, '0);
    issue(ACT_QUERY, 8, 8, 0, '0);
    issue(ACT_QUERY, 31, 31, 31, '0);
    issue(ACT_WR_X, 8, 0, 0, 32'h7FFFFFFF);
    issue(ACT_WR_X, 7, 0, 0, 32'h80000000);
    issue(ACT_QUERY, 5, 5, 5, '0);

    // Random phases, each under its own search limit.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: set_limit('0);
        2: set_limit(31'h7FFFFFFF);
        3: set_limit(31'd1);
        4: set_limit(31'($urandom_range(65536, 400000)));
        5: set_limit(LIMIT_RESET);
        default: ;
      endcase
      for (int n = 0; n < 75; n++) begin
        a = $urandom_range(0, 99);
        if (a < 45) begin
          paced(ACT_QUERY, $urandom_range(2, 5), $urandom_range(2, 5),
                $urandom_range(2, 5), $urandom);
        end else if (a < 50) begin
          x = $urandom_range(2, 15); y = $urandom_range(2, 15); z = $urandom_range(2, 15);
          case ($urandom_range(0, 2))
            0: x = bad_index();
            1: y = bad_index();
            default: z = bad_index();
          endcase
          paced(ACT_QUERY, x, y, z, $urandom);
        end else if (a < 78) begin
          x = $urandom_range(0, 19) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 16);
          paced(ACT_WR_FRAC, x, $urandom_range(1, 16), $urandom_range(1, 16), any_frac());
        end else if (a < 95) begin
          x = $urandom_range(0, 19) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 16);
          paced(3'($urandom_range(1, 3)), x, x, x, any_coord(x));
        end else begin
          paced(3'($urandom_range(5, 7)), $urandom_range(0, 31), $urandom_range(0, 31),
                $urandom_range(0, 31), $urandom);
        end
      end
    end

    // Drain and give the verdict.
    pause(1);
    while (pending != 0 || busy) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/lsd_pkg.sv
rtl/core/lsd_ram.sv
rtl/core/lsd_ctrl.sv
rtl/core/lsd_dp.sv
rtl/core/local_signed_distance_3d.sv
tb/sv/lsd_checker.sv
tb/sv/tb.sv
